### rtl/core/delta_list_event_timer_macros.svh
// Assertion macros for the checker of the delta list event timer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef DELTA_LIST_EVENT_TIMER_MACROS_SVH
`define DELTA_LIST_EVENT_TIMER_MACROS_SVH

// Checked on every clock edge outside of reset.
`define DLET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DLET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/dlet_pkg.sv
// Shared types and constants of the delta list event timer.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package dlet_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DELAY_BITS  = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS);
  // Running sum of deltas, signed, starting at minus the head's elapsed count.
  localparam int SUM_W = DELAY_BITS + IDX_W + 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_QUEUED = 2'd0,
    STATUS_FIRED  = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                   operation;
    logic [DELAY_BITS-1:0] delay;
    logic [ID_BITS-1:0]    event_id;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ID_BITS-1:0] fired_id;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [DELAY_BITS-1:0] delta;
    logic [ID_BITS-1:0]    id;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/delta_list_event_timer.sv
// Channel    | Direction | Handshake                  | Word
// -----------+-----------+----------------------------+-----------------------------
// command    | in        | start high while busy low  | cmd_i (operation, delay, id)
// result     | out       | result_valid_o, one cycle  | result_o (status, id, last)
//
// An add that is queued holds busy while the walk visits one queued delta
// per cycle through a single adder and comparator, then S_FIX forms the
// offset and S_INSERT shifts the entries and writes the new one.
// A tick without expiry does not hold busy; a tick that fires holds busy while
// it emits its words, at most 16, on consecutive cycles.
// Reset (asynchronous, active low) empties the queue; the entry storage itself is
// not cleared. The receiver cannot stall: each word is shown for exactly one cycle.
// Depends on dlet_pkg.
`default_nettype none

module delta_list_event_timer
  import dlet_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd_i,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_FIX    = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_FIRE   = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [DELAY_BITS-1:0]  elapsed_q, elapsed_d;
  logic [NUM_W-1:0]       nfire_q, nfire_d;
  logic                   result_valid_q, result_valid_d;
  result_t                result_q, result_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [DELAY_BITS-1:0]  delay_q, delay_d;
  logic [ID_BITS-1:0]     id_q, id_d;
  logic [DELAY_BITS-1:0]  diff_q, diff_d;

  entry_t entries_q [QUEUE_DEPTH];
  entry_t above [QUEUE_DEPTH];
  entry_t below [QUEUE_DEPTH];

  logic                    accept;
  entry_t                  rd_entry;
  logic signed [SUM_W-1:0] walk_sum;
  logic signed [SUM_W-1:0] delay_ext;
  logic                    walk_stop;
  logic [DELAY_BITS:0]     elapsed_inc;
  logic                    tick_fire;
  logic                    fire_last;
  logic [DELAY_BITS-1:0]   new_delta;
  logic [DELAY_BITS-1:0]   adj_delta;
  logic [IDX_W:0]          pos_nx;
  logic                    do_pop;
  logic                    do_insert;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Neighbor taps for the shift moves of pop and insert.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_taps
    if (g < QUEUE_DEPTH - 1) begin : g_up
      assign above[g] = entries_q[g+1];
    end else begin : g_up_end
      assign above[g] = entries_q[g];
    end
    if (g > 0) begin : g_dn
      assign below[g] = entries_q[g-1];
    end else begin : g_dn_end
      assign below[g] = entries_q[g];
    end
  end

  assign rd_entry    = entries_q[pos_q];
  assign walk_sum    = sum_q + $signed({{(SUM_W-DELAY_BITS){1'b0}}, rd_entry.delta});
  assign delay_ext   = $signed({{(SUM_W-DELAY_BITS){1'b0}}, delay_q});
  assign walk_stop   = (CNT_W'(pos_q) == count_q) || (delay_ext <= walk_sum);
  assign elapsed_inc = {1'b0, elapsed_q} + {{DELAY_BITS{1'b0}}, 1'b1};
  assign tick_fire   = (elapsed_inc >= {1'b0, entries_q[0].delta});
  assign fire_last   = (count_q == CNT_W'(1)) || (entries_q[1].delta != '0) ||
                       (nfire_q == NUM_W'(MAX_RESULTS - 1));
  // A new head keeps its full delay; otherwise its delta is the offset to its
  // predecessor. Either way the successor loses the offset kept in diff_q.
  assign new_delta   = (pos_q == '0) ? delay_q : diff_q;
  assign adj_delta   = rd_entry.delta - diff_q;
  assign pos_nx      = {1'b0, pos_q} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    elapsed_d      = elapsed_q;
    nfire_d        = nfire_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    sum_d          = sum_q;
    pos_d          = pos_q;
    delay_d        = delay_q;
    id_d           = id_q;
    diff_d         = diff_q;
    do_pop         = 1'b0;
    do_insert      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.operation == OP_ADD) begin
            if (cmd_i.delay == '0) begin
              result_valid_d = 1'b1;
              result_d       = '{status: STATUS_FIRED, fired_id: cmd_i.event_id, last: 1'b1};
            end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
              result_valid_d = 1'b1;
              result_d       = '{status: STATUS_FULL, fired_id: '0, last: 1'b1};
            end else begin
              delay_d = cmd_i.delay;
              id_d    = cmd_i.event_id;
              sum_d   = -$signed({{(SUM_W-DELAY_BITS){1'b0}}, elapsed_q});
              pos_d   = '0;
              state_d = S_WALK;
            end
          end else if (count_q != '0) begin
            if (tick_fire) begin
              elapsed_d = '0;
              nfire_d   = '0;
              state_d   = S_FIRE;
            end else begin
              elapsed_d = elapsed_inc[DELAY_BITS-1:0];
            end
          end
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          state_d = S_FIX;
        end else begin
          sum_d = walk_sum;
          pos_d = pos_q + IDX_W'(1);
        end
      end
      S_FIX: begin
        diff_d  = delay_q - sum_q[DELAY_BITS-1:0];
        state_d = S_INSERT;
      end
      S_INSERT: begin
        do_insert      = 1'b1;
        count_d        = count_q + CNT_W'(1);
        if (pos_q == '0) begin
          elapsed_d = '0;
        end
        result_valid_d = 1'b1;
        result_d       = '{status: STATUS_QUEUED, fired_id: '0, last: 1'b1};
        state_d        = S_IDLE;
      end
      S_FIRE: begin
        do_pop         = 1'b1;
        count_d        = count_q - CNT_W'(1);
        nfire_d        = nfire_q + NUM_W'(1);
        result_valid_d = 1'b1;
        result_d       = '{status: STATUS_FIRED, fired_id: entries_q[0].id, last: fire_last};
        if (fire_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      elapsed_q      <= '0;
      nfire_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      elapsed_q      <= elapsed_d;
      nfire_q        <= nfire_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    sum_q    <= sum_d;
    pos_q    <= pos_d;
    delay_q  <= delay_d;
    id_q     <= id_d;
    diff_q   <= diff_d;
  end

  // Pop moves every entry one place toward the head. Insert writes the new
  // entry at pos_q, the adjusted successor one place above, and moves the rest up.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_pop) begin
        entries_q[i] <= above[i];
      end else if (do_insert) begin
        if ({1'b0, pos_q} == (IDX_W+1)'(i)) begin
          entries_q[i] <= '{delta: new_delta, id: id_q};
        end else if (pos_nx == (IDX_W+1)'(i)) begin
          entries_q[i] <= '{delta: adj_delta, id: rd_entry.id};
        end else if (pos_nx < (IDX_W+1)'(i)) begin
          entries_q[i] <= below[i];
        end
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

### rtl/core/dlet_chk.sv
// Port-level checker for the delta list event timer, bound to the top level.
// Depends on dlet_pkg and delta_list_event_timer_macros.svh.
`default_nettype none
`include "delta_list_event_timer_macros.svh"

module dlet_chk
  import dlet_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd_i,
  input logic    result_valid_o,
  input result_t result_o
);

  // An add with zero delay fires at once as a single word.
  `DLET_ASSERT(a_zero_delay_fires, start && !busy && cmd_i.operation == OP_ADD && cmd_i.delay == '0 |=> result_valid_o && result_o.status == STATUS_FIRED && result_o.last, "zero-delay add did not fire at once")

  // Every accepted add either answers at once or keeps the block busy.
  `DLET_ASSERT(a_add_answered, start && !busy && cmd_i.operation == OP_ADD |=> busy || result_valid_o, "accepted add left neither a word nor busy")

  // A fired burst runs on consecutive cycles until its last word.
  `DLET_ASSERT(a_burst_contiguous, result_valid_o && !result_o.last |=> result_valid_o && result_o.status == STATUS_FIRED, "fired burst broken before its last word")

  // Only fired words continue a burst, and only they carry an id.
  `DLET_ASSERT(a_non_fired_word, result_valid_o && result_o.status != STATUS_FIRED |-> result_o.last && result_o.fired_id == '0, "queued or full word not final or carries an id")

  // No word appears in the cycle right after reset.
  `DLET_ASSERT_ALWAYS(a_quiet_after_reset, !rst_ni |=> !result_valid_o, "word shown right after reset")

endmodule

bind delta_list_event_timer dlet_chk u_dlet_chk (.*);

`default_nettype wire

### tb/delta_list_event_timer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for delta_list_event_timer: a mirrored delta list predicts
// every result word, and the words from the block are compared in order.
// Depends on dlet_pkg and the delta_list_event_timer RTL.

module delta_list_event_timer_test;
  import dlet_pkg::*;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 255;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 10;

  // Mirrors the timer queue and holds the result words it still owes.
  class expiry_tracker;
    entry_t                slots[QUEUE_DEPTH];
    int                    used = 0;
    logic [DELAY_BITS-1:0] elapsed = '0;
    result_t               due_words[$];
    int                    mismatches = 0;

    function void push(status_e s, logic [ID_BITS-1:0] id, logic fin);
      result_t r;
      r.status   = s;
      r.fired_id = id;
      r.last     = fin;
      due_words.push_back(r);
    endfunction

    function void note_command(cmd_t c);
      longint                run_sum;
      int                    pos;
      int                    k;
      int                    fired;
      logic                  more;
      logic [DELAY_BITS-1:0] nd;
      logic [ID_BITS-1:0]    fired_id;
      if (c.operation == OP_ADD) begin
        if (c.delay == '0) begin
          push(STATUS_FIRED, c.event_id, 1'b1);
        end else if (used >= QUEUE_DEPTH) begin
          push(STATUS_FULL, '0, 1'b1);
        end else begin
          // Walk to the first entry that expires no earlier than the new one.
          run_sum = -longint'(elapsed);
          pos = 0;
          while (pos < used && longint'(c.delay) > run_sum + longint'(slots[pos].delta)) begin
            run_sum += longint'(slots[pos].delta);
            pos++;
          end
          if (pos == 0) begin
            nd = c.delay;
            if (used > 0) slots[0].delta = slots[0].delta - elapsed - c.delay;
            elapsed = '0;
          end else begin
            nd = DELAY_BITS'(longint'(c.delay) - run_sum);
            if (pos < used) slots[pos].delta = slots[pos].delta - nd;
          end
          for (k = used; k > pos; k--) slots[k] = slots[k-1];
          slots[pos].delta = nd;
          slots[pos].id    = c.event_id;
          used++;
          push(STATUS_QUEUED, '0, 1'b1);
        end
        return;
      end
      if (used == 0) return;
      elapsed++;
      if (elapsed < slots[0].delta) return;
      // The head expired: pop it and the zero-delta entries behind it, at most MAX_RESULTS.
      fired = 0;
      elapsed = '0;
      do begin
        fired_id = slots[0].id;
        for (k = 0; k < used - 1; k++) slots[k] = slots[k+1];
        used--;
        fired++;
        more = (used > 0 && slots[0].delta == '0 && fired < MAX_RESULTS);
        push(STATUS_FIRED, fired_id, !more);
      end while (more);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s: expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                 $realtime, what, want.status, want.fired_id, want.last,
                 got.status, got.fired_id, got.last);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status || got.fired_id !== want.fired_id ||
          got.last !== want.last)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  cmd_t    cmd_i = '0;
  logic    result_valid_o;
  result_t result_o;

  expiry_tracker tracker = new;
  int cycles = 0;
  int sent = 0;

  delta_list_event_timer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Words are checked before the command of the same edge is noted, since a
  // word always belongs to an earlier command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) tracker.check_word(result_o);
      if (start && !busy) tracker.note_command(cmd_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** delta_list_event_timer: FAILED **");
      $finish;
    end
  end

  task automatic issue(input op_e op, input logic [DELAY_BITS-1:0] dly,
                       input logic [ID_BITS-1:0] id);
    cmd_t c;
    c.operation = op;
    c.delay     = dly;
    c.event_id  = id;
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic pause(input int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (tracker.due_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DELAY_BITS-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    // Long delays are rare: most of them stay queued for the rest of the run.
    if (r < 9) return DELAY_BITS'($urandom_range(1, 65535));
    if (r < 25) return DELAY_BITS'($urandom_range(1, 3));
    return DELAY_BITS'($urandom_range(1, 24));
  endfunction

  initial begin
    int   burst;
    int   chance;
    int   gap;
    int   k;
    logic drained;
    drained = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero delays fire at once, and a tick on an empty queue does nothing.
    issue(OP_ADD, '0, 8'h00);
    issue(OP_ADD, '0, 8'hFF);
    issue(OP_TICK, 16'hFFFF, 8'hFF);
    issue(OP_ADD, 16'hFFFF, 8'hFF);
    // Two events with the same expiry become the new head and fire together.
    issue(OP_ADD, 16'd1, 8'h5A);
    issue(OP_ADD, 16'd1, 8'hA5);
    issue(OP_TICK, '0, '0);
    // Fill the queue with equal expiries, overflow it, then fire fifteen at once.
    for (k = 0; k < 15; k++) issue(OP_ADD, 16'd2, 8'(8'h10 + k));
    issue(OP_ADD, 16'd7, 8'h77);
    issue(OP_TICK, '0, '0);
    issue(OP_TICK, '0, '0);
    pause(2);

    while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      burst  = $urandom_range(1, 12);
      chance = $urandom_range(20, 80);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(1, 100) <= chance)
          issue(OP_ADD, pick_delay(), ID_BITS'($urandom_range(0, 255)));
        else
          issue(OP_TICK, DELAY_BITS'($urandom), ID_BITS'($urandom));
      end
      if (!drained && sent >= DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
        pause(1);
        wait_drained();
        drained = 1'b1;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause(gap);
      end
    end
    pause(1);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.due_words.size() == 0) begin
      $display("** delta_list_event_timer: PASSED **");
    end else begin
      $display("** delta_list_event_timer: FAILED **");
    end
    $finish;
  end

endmodule
